### rtl/core/lcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_pkg: shared types and constants of the Li Chao minimum-line DP block
// Tree geometry, node word layout and the line record used by the datapath.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int HEIGHT_BITS = 20;
    localparam int NODE_BITS   = HEIGHT_BITS + 1;
    localparam int SLOPE_W     = HEIGHT_BITS + 2;
    localparam int PROD_W      = SLOPE_W + HEIGHT_BITS + 1;
    localparam int EPOCH_W     = 8;
    localparam int WEIGHT_W    = 21;
    localparam int COST_W      = 64;

    localparam logic [HEIGHT_BITS-1:0] MAX_POS   = {HEIGHT_BITS{1'b1}};
    localparam logic [EPOCH_W-1:0]     MAX_EPOCH = {EPOCH_W{1'b1}};
    localparam logic signed [COST_W-1:0] EMPTY_VALUE = 64'sd1000000000000000000;

    // A line as the datapath carries it; an invalid line is the empty line.
    typedef struct packed {
        logic                      valid;
        logic signed [SLOPE_W-1:0] k;
        logic signed [COST_W-1:0]  b;
    } line_t;

    // One word of the node memory. The entry counts only when its epoch matches.
    typedef struct packed {
        logic                      valid;
        logic [EPOCH_W-1:0]        epoch;
        logic signed [SLOPE_W-1:0] k;
        logic signed [COST_W-1:0]  b;
    } node_word_t;

endpackage
`default_nettype wire

### rtl/core/lcm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_pillar_if / lcm_result_if: valid-ready channels of the DP block
// Input beats carry one pillar, output beats carry one cost.
// ----------------------------------------------------------------------------
interface lcm_pillar_if;
    logic                                valid;
    logic                                ready;
    logic [lcm_pkg::HEIGHT_BITS-1:0]     height;
    logic signed [lcm_pkg::WEIGHT_W-1:0] weight;
    logic                                first;

    modport source (output valid, height, weight, first, input ready);
    modport sink   (input valid, height, weight, first, output ready);
endinterface

interface lcm_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [lcm_pkg::COST_W-1:0] cost;

    modport source (output valid, cost, input ready);
    modport sink   (input valid, cost, output ready);
endinterface
`default_nettype wire

### rtl/core/lcm_line_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcm_line_eval: shared line evaluator
// Computes k*pos + b in two registered stages; the empty line gives 1e18.
// ----------------------------------------------------------------------------
module lcm_line_eval (
    input  wire logic                            clk,
    input  wire lcm_pkg::line_t                  line,
    input  wire logic [lcm_pkg::HEIGHT_BITS-1:0] pos,
    output logic signed [lcm_pkg::COST_W-1:0]    value
);

    logic signed [lcm_pkg::PROD_W-1:0] prod_reg;
    logic signed [lcm_pkg::COST_W-1:0] b_reg;
    logic                              valid_reg;
    logic signed [lcm_pkg::COST_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        prod_reg  <= lcm_pkg::PROD_W'(line.k * $signed({1'b0, pos}));
        b_reg     <= line.b;
        valid_reg <= line.valid;
        if (valid_reg)
        begin
            value_reg <= lcm_pkg::COST_W'(prod_reg) + b_reg;
        end
        else
        begin
            value_reg <= lcm_pkg::EMPTY_VALUE;
        end
    end

    assign value = value_reg;

endmodule
`default_nettype wire

### rtl/core/li_chao_min_line_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// li_chao_min_line_dp: Li Chao tree minimum-line dynamic program
// Streams pillars, answers a DP cost per pillar and inserts its line.
// ----------------------------------------------------------------------------
// Flow: h*h first, then a query of L = HEIGHT_BITS + 1 levels for the cost, then
// an insert walked from the root; a first pillar skips the query. One pillar is
// in flight at a time: a new beat is taken only in idle, after the cost has gone
// to the output register. The shared two-stage line evaluator and the node
// memory, one read per level, serve both walks.
// Reset: a clearing pass empties the node memory; the same pass runs again
// on the first-flagged item that wraps the epoch.
// ----------------------------------------------------------------------------
module li_chao_min_line_dp (
    input  wire logic   clk,
    input  wire logic   rst_n,
    lcm_pillar_if.sink  pillar,
    lcm_result_if.source result
);

    localparam int HB = lcm_pkg::HEIGHT_BITS;
    localparam int NB = lcm_pkg::NODE_BITS;
    localparam int SW = lcm_pkg::SLOPE_W;
    localparam int CW = lcm_pkg::COST_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_HH, ST_Q_RD, ST_Q_LD, ST_Q_EV,
        ST_COST, ST_LINE, ST_I_RD, ST_I_LD, ST_I_CMP, ST_FIN
    } state_t;

    // Which comparison of an insert level is running.
    typedef enum logic [1:0] {
        PH_MID, PH_LO, PH_HI, PH_LEAF
    } phase_t;

    state_t                 state_reg;
    phase_t                 phase_reg;
    logic [1:0]             step_reg;
    logic                   busy_reg;
    logic                   first_level_reg;
    logic [NB-1:0]          clr_cnt_reg;
    logic [lcm_pkg::EPOCH_W-1:0] epoch_reg;

    logic [HB-1:0]          h_reg;
    logic signed [lcm_pkg::WEIGHT_W-1:0] w_reg;
    logic                   first_reg;
    logic [NB-1:0]          node_reg;
    logic [HB-1:0]          lo_reg;
    logic [HB-1:0]          hi_reg;
    lcm_pkg::line_t         cur_reg;
    lcm_pkg::line_t         here_reg;
    logic signed [CW-1:0]   a_reg;
    logic signed [CW-1:0]   best_reg;
    logic signed [CW-1:0]   hh_reg;
    logic signed [CW-1:0]   sum_reg;
    logic signed [CW-1:0]   cost_reg;
    logic                   out_valid_reg;
    logic signed [CW-1:0]   out_cost_reg;

    // Node memory: one write and one registered read per cycle.
    lcm_pkg::node_word_t    mem [2**NB];
    lcm_pkg::node_word_t    rdata_reg;
    logic                   mem_we;
    logic [NB-1:0]          mem_waddr;
    lcm_pkg::node_word_t    mem_wdata;

    lcm_pkg::line_t         node_line;
    lcm_pkg::line_t         ev_line;
    logic [HB-1:0]          ev_pos;
    logic signed [CW-1:0]   ev_value;
    logic [HB-1:0]          mid;
    logic [HB-1:0]          cmp_pos;
    logic                   lt;
    logic signed [CW-1:0]   w_ext;
    logic                   accept;

    assign mid    = HB'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign w_ext  = CW'(w_reg);
    assign lt     = a_reg < ev_value;
    assign accept = pillar.valid && pillar.ready;

    assign pillar.ready = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.cost  = out_cost_reg;

    // A stored line counts only when it was written in the current epoch.
    always_comb
    begin
        node_line.valid = rdata_reg.valid && (rdata_reg.epoch == epoch_reg);
        node_line.k     = rdata_reg.k;
        node_line.b     = rdata_reg.b;
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_MID:  cmp_pos = mid;
            PH_LO:   cmp_pos = lo_reg;
            PH_HI:   cmp_pos = hi_reg;
            default: cmp_pos = lo_reg;
        endcase
    end

    // Operand selection for the shared evaluator.
    always_comb
    begin
        ev_line = here_reg;
        ev_pos  = h_reg;
        priority if (state_reg == ST_HH)
        begin
            ev_line.valid = 1'b1;
            ev_line.k     = $signed(SW'(h_reg));
            ev_line.b     = '0;
        end
        else if (state_reg == ST_I_CMP)
        begin
            ev_line = (step_reg == 2'd0) ? cur_reg : here_reg;
            ev_pos  = cmp_pos;
        end
        else
        begin
            ev_line = here_reg;
        end
    end

    // Memory write port: clearing pass or a node update during insert.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = node_reg;
        mem_wdata = '{valid: cur_reg.valid, epoch: epoch_reg, k: cur_reg.k, b: cur_reg.b};
        if (state_reg == ST_CLEAR)
        begin
            mem_we          = 1'b1;
            mem_waddr       = clr_cnt_reg;
            mem_wdata.valid = 1'b0;
        end
        else if (state_reg == ST_I_CMP && step_reg == 2'd3 && lt &&
                 (phase_reg == PH_MID || phase_reg == PH_LEAF))
        begin
            // The carried line goes into the node; on a swap it is the new occupant.
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[node_reg];
    end

    lcm_line_eval u_eval (
        .clk   (clk),
        .line  (ev_line),
        .pos   (ev_pos),
        .value (ev_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            phase_reg       <= PH_MID;
            step_reg        <= '0;
            busy_reg        <= 1'b0;
            first_level_reg <= 1'b0;
            clr_cnt_reg     <= '0;
            epoch_reg       <= '0;
            sum_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // The handoff in ST_FIN decides the output register by itself.
            if (result.valid && result.ready && state_reg != ST_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        h_reg     <= pillar.height;
                        w_reg     <= pillar.weight;
                        first_reg <= pillar.first;
                        busy_reg  <= 1'b1;
                        step_reg  <= '0;
                        if (pillar.first && epoch_reg == lcm_pkg::MAX_EPOCH)
                        begin
                            epoch_reg   <= '0;
                            clr_cnt_reg <= '0;
                            state_reg   <= ST_CLEAR;
                        end
                        else
                        begin
                            if (pillar.first)
                            begin
                                epoch_reg <= epoch_reg + 1'b1;
                            end
                            state_reg <= ST_HH;
                        end
                    end
                end

                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= busy_reg ? ST_HH : ST_IDLE;
                    end
                end

                ST_HH:
                begin
                    // The step count is reloaded when the next node is loaded.
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        hh_reg          <= ev_value;
                        node_reg        <= NB'(1);
                        lo_reg          <= '0;
                        hi_reg          <= lcm_pkg::MAX_POS;
                        first_level_reg <= 1'b1;
                        if (first_reg)
                        begin
                            sum_reg   <= w_ext;
                            cost_reg  <= '0;
                            state_reg <= ST_LINE;
                        end
                        else
                        begin
                            state_reg <= ST_Q_RD;
                        end
                    end
                end

                ST_Q_RD:
                begin
                    state_reg <= ST_Q_LD;
                end

                ST_Q_LD:
                begin
                    here_reg  <= node_line;
                    step_reg  <= '0;
                    state_reg <= ST_Q_EV;
                end

                ST_Q_EV:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        if (first_level_reg || ev_value < best_reg)
                        begin
                            best_reg <= ev_value;
                        end
                        first_level_reg <= 1'b0;
                        if (lo_reg == hi_reg)
                        begin
                            state_reg <= ST_COST;
                        end
                        else
                        begin
                            if (h_reg <= mid)
                            begin
                                node_reg <= {node_reg[NB-2:0], 1'b0};
                                hi_reg   <= mid;
                            end
                            else
                            begin
                                node_reg <= {node_reg[NB-2:0], 1'b1};
                                lo_reg   <= mid + 1'b1;
                            end
                            state_reg <= ST_Q_RD;
                        end
                    end
                end

                ST_COST:
                begin
                    cost_reg  <= hh_reg + sum_reg + best_reg;
                    sum_reg   <= sum_reg + w_ext;
                    state_reg <= ST_LINE;
                end

                ST_LINE:
                begin
                    // New line (-2h, h*h - sum + cost), walked in from the root.
                    cur_reg.valid <= 1'b1;
                    cur_reg.k     <= -$signed({SW'(h_reg)} << 1);
                    cur_reg.b     <= hh_reg - sum_reg + cost_reg;
                    node_reg      <= NB'(1);
                    lo_reg        <= '0;
                    hi_reg        <= lcm_pkg::MAX_POS;
                    state_reg     <= ST_I_RD;
                end

                ST_I_RD:
                begin
                    state_reg <= ST_I_LD;
                end

                ST_I_LD:
                begin
                    here_reg  <= node_line;
                    step_reg  <= '0;
                    phase_reg <= (lo_reg == hi_reg) ? PH_LEAF : PH_MID;
                    state_reg <= ST_I_CMP;
                end

                ST_I_CMP:
                begin
                    // Four steps per comparison; the count wraps back to zero.
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd2)
                    begin
                        a_reg <= ev_value;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        unique case (phase_reg)
                            PH_LEAF:
                            begin
                                state_reg <= ST_FIN;
                            end
                            PH_MID:
                            begin
                                if (lt)
                                begin
                                    here_reg <= cur_reg;
                                    cur_reg  <= here_reg;
                                end
                                phase_reg <= PH_LO;
                            end
                            PH_LO:
                            begin
                                if (lt)
                                begin
                                    node_reg  <= {node_reg[NB-2:0], 1'b0};
                                    hi_reg    <= mid;
                                    state_reg <= ST_I_RD;
                                end
                                else
                                begin
                                    phase_reg <= PH_HI;
                                end
                            end
                            PH_HI:
                            begin
                                if (lt)
                                begin
                                    node_reg  <= {node_reg[NB-2:0], 1'b1};
                                    lo_reg    <= mid + 1'b1;
                                    state_reg <= ST_I_RD;
                                end
                                else
                                begin
                                    state_reg <= ST_FIN;
                                end
                            end
                        endcase
                    end
                end

                ST_FIN:
                begin
                    // Hand the cost to the output register once it is free.
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cost_reg  <= cost_reg;
                        busy_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### dv/lcm_tb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_tb_if: note on the channel interfaces used by the testbench
// The testbench binds the block through the interfaces of rtl/core/lcm_if.sv,
// so this file only carries shared testbench types.
// ----------------------------------------------------------------------------
package lcm_tb_pkg;

    // One row of the directed pillar plan.
    typedef struct packed {
        logic [19:0]        height;
        logic signed [20:0] weight;
        logic               first;
        logic               typed;
        logic [63:0]        cost;
    } pillar_row_t;

endpackage

### dv/li_chao_min_line_dp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// li_chao_min_line_dp_tb: self-checking bench of the Li Chao DP block
// Drives pillar beats (directed plan, then random sequences) under random
// bursts and receiver stalls, predicts untyped costs by a sparse tree model
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module li_chao_min_line_dp_tb;

    typedef logic [63:0] u64;

    localparam int  HB         = lcm_pkg::HEIGHT_BITS;
    localparam int  WW         = lcm_pkg::WEIGHT_W;
    localparam u64  EMPTY_COST = 64'd1000000000000000000;
    localparam int  RAND_ITEMS = 750;
    // The limit covers the reset clearing pass and about 800 pillars plus all
    // stalls, many times over.
    localparam longint CYCLE_LIMIT = 64'd16000000;

    logic clk;
    logic rst_n;

    lcm_pillar_if pillar ();
    lcm_result_if result ();

    li_chao_min_line_dp i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pillar (pillar.sink),
        .result (result.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Cost predictor: a sparse copy of the tree. A node holds a line only
    // while it has an entry in the maps; a missing entry is the empty line.
    // ------------------------------------------------------------------
    u64 node_slope[int];
    u64 node_icpt[int];
    u64 run_sum;

    function automatic u64 line_value(bit v, u64 k, u64 b, u64 pos);
        return v ? k * pos + b : EMPTY_COST;
    endfunction

    function automatic bit lower(u64 a, u64 b);
        return $signed(a) < $signed(b);
    endfunction

    function automatic u64 min_at(int unsigned pos);
        int unsigned node;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        u64          best;
        u64          v;
        bit          have;
        node = 1;
        lo   = 0;
        hi   = (1 << HB) - 1;
        have = 1'b0;
        best = '0;
        forever
        begin
            v = node_slope.exists(node) ?
                line_value(1'b1, node_slope[node], node_icpt[node], pos) : EMPTY_COST;
            if (!have || lower(v, best))
            begin
                best = v;
                have = 1'b1;
            end
            if (lo == hi)
                return best;
            mid = (lo + hi) >> 1;
            if (pos <= mid)
            begin
                node = node << 1;
                hi   = mid;
            end
            else
            begin
                node = (node << 1) | 1;
                lo   = mid + 1;
            end
        end
    endfunction

    function automatic void add_line(u64 k_in, u64 b_in);
        int unsigned node;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          cv;
        bit          hv;
        u64          ck;
        u64          cb;
        u64          hk;
        u64          hb;
        bit          tv;
        u64          tk;
        u64          tbv;
        node = 1;
        lo   = 0;
        hi   = (1 << HB) - 1;
        cv   = 1'b1;
        ck   = k_in;
        cb   = b_in;
        forever
        begin
            hv = node_slope.exists(node);
            hk = hv ? node_slope[node] : '0;
            hb = hv ? node_icpt[node] : EMPTY_COST;
            if (lo == hi)
            begin
                if (lower(line_value(cv, ck, cb, lo), line_value(hv, hk, hb, lo)))
                begin
                    if (cv)
                    begin
                        node_slope[node] = ck;
                        node_icpt[node]  = cb;
                    end
                    else
                    begin
                        node_slope.delete(node);
                        node_icpt.delete(node);
                    end
                end
                return;
            end
            mid = (lo + hi) >> 1;
            if (lower(line_value(cv, ck, cb, mid), line_value(hv, hk, hb, mid)))
            begin
                // The carried line wins the midpoint and stays; the old one moves on.
                tv = hv; tk = hk; tbv = hb;
                hv = cv; hk = ck; hb = cb;
                cv = tv; ck = tk; cb = tbv;
                if (hv)
                begin
                    node_slope[node] = hk;
                    node_icpt[node]  = hb;
                end
                else
                begin
                    node_slope.delete(node);
                    node_icpt.delete(node);
                end
            end
            if (lower(line_value(cv, ck, cb, lo), line_value(hv, hk, hb, lo)))
            begin
                node = node << 1;
                hi   = mid;
            end
            else if (lower(line_value(cv, ck, cb, hi), line_value(hv, hk, hb, hi)))
            begin
                node = (node << 1) | 1;
                lo   = mid + 1;
            end
            else
                return;
        end
    endfunction

    // Advance the model by one accepted pillar and return its cost.
    function automatic u64 pillar_cost(logic [HB-1:0] h, logic signed [WW-1:0] w,
                                       logic f);
        u64 pos;
        u64 sq;
        u64 w64;
        u64 c;
        pos = u64'(h);
        sq  = pos * pos;
        w64 = u64'(signed'(w));
        if (f)
        begin
            node_slope.delete();
            node_icpt.delete();
            run_sum = w64;
            c       = '0;
        end
        else
        begin
            c       = sq + run_sum + min_at(h);
            run_sum = run_sum + w64;
        end
        add_line(u64'(0) - 2 * pos, sq - run_sum + c);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Directed plan. The cost is typed in only where it is plain: the very
    // first pillar runs on an empty tree with no first flag, so it costs the
    // empty-line value; a first-flagged pillar always costs zero.
    // ------------------------------------------------------------------
    localparam logic [19:0]        HMAX = {20{1'b1}};
    localparam logic signed [20:0] WMIN = -21'sd1048576;
    localparam logic signed [20:0] WMAX = 21'sd1048575;

    lcm_tb_pkg::pillar_row_t plan [0:17] = '{
        '{20'd0,      21'sd5,   1'b0, 1'b1, EMPTY_COST},
        '{20'd3,      -21'sd2,  1'b0, 1'b0, 64'd0},
        '{HMAX,       WMIN,     1'b1, 1'b1, 64'd0},
        '{20'd0,      WMAX,     1'b0, 1'b0, 64'd0},
        '{HMAX,       WMAX,     1'b0, 1'b0, 64'd0},
        '{20'd524288, 21'sd0,   1'b0, 1'b0, 64'd0},
        '{20'd524287, -21'sd1,  1'b0, 1'b0, 64'd0},
        '{20'd0,      WMAX,     1'b1, 1'b1, 64'd0},
        '{20'd0,      WMIN,     1'b0, 1'b0, 64'd0},
        '{20'd0,      WMIN,     1'b0, 1'b0, 64'd0},
        '{20'd1,      21'sd7,   1'b0, 1'b0, 64'd0},
        '{HMAX,       21'sd0,   1'b0, 1'b0, 64'd0},
        '{20'd7,      21'sd3,   1'b1, 1'b1, 64'd0},
        '{20'd7,      21'sd3,   1'b0, 1'b0, 64'd0},
        '{20'd7,      21'sd3,   1'b0, 1'b0, 64'd0},
        '{20'd2,      -21'sd9,  1'b0, 1'b0, 64'd0},
        '{20'd12,     21'sd100, 1'b0, 1'b0, 64'd0},
        '{HMAX,       WMIN,     1'b0, 1'b0, 64'd0}
    };

    u64 cost_q[$];
    bit failed;
    bit stim_done;
    int results_seen;

    // Present one pillar beat at the falling edge and hold it until accepted.
    // The prediction is taken at the accepting rising edge.
    task automatic send_pillar(logic [HB-1:0] h, logic signed [WW-1:0] w,
                               logic f, bit typed, u64 typed_cost);
        u64 c;
        @(negedge clk);
        pillar.valid  <= 1'b1;
        pillar.height <= h;
        pillar.weight <= w;
        pillar.first  <= f;
        do
            @(posedge clk);
        while (!pillar.ready);
        c = pillar_cost(h, w, f);
        cost_q.push_back(typed ? typed_cost : c);
    endtask

    task automatic pause_sender(int n);
        repeat (n)
        begin
            @(negedge clk);
            pillar.valid <= 1'b0;
        end
    endtask

    // Burst bookkeeping for the sender: random burst lengths, random gaps.
    int burst_left;

    task automatic maybe_gap();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 40));
        end
        burst_left--;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int                   sent;
        int                   seq_len;
        bit                   narrow;
        logic [HB-1:0]        h;
        logic signed [WW-1:0] w;
        rst_n         = 1'b0;
        pillar.valid  = 1'b0;
        pillar.height = '0;
        pillar.weight = '0;
        pillar.first  = 1'b0;
        failed        = 1'b0;
        stim_done     = 1'b0;
        run_sum       = '0;
        burst_left    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[i])
        begin
            maybe_gap();
            send_pillar(plan[i].height, plan[i].weight, plan[i].first,
                        plan[i].typed, plan[i].cost);
        end

        // Random sequences: most start with a first-flagged pillar and carry
        // random content; a few continue the running sequence unflagged.
        // Narrow height ranges make lines collide and swap deep in the tree.
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            seq_len = $urandom_range(2, 30);
            narrow  = ($urandom_range(0, 2) == 0);
            for (int j = 0; j < seq_len && sent < RAND_ITEMS; j++)
            begin
                h = narrow ? HB'($urandom_range(0, 31)) : HB'($urandom);
                case ($urandom_range(0, 3))
                    0:       w = WMIN;
                    1:       w = WMAX;
                    2:       w = WW'($urandom_range(0, 200)) - 21'sd100;
                    default: w = WW'($urandom);
                endcase
                maybe_gap();
                send_pillar(h, w, (j == 0) && ($urandom_range(0, 7) != 0), 1'b0, '0);
                sent++;
            end
        end
        pause_sender(1);
        stim_done = 1'b1;

        wait (cost_q.size() == 0);
        // The last pillar's insert ends before its cost beat; wait on before the verdict.
        repeat (600) @(posedge clk);
        if (!failed)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: a stall pattern that changes mode at random, with
    // stretches of no stalling, plus one long hold-off so that the block
    // backs up and stops accepting pillars while the sender keeps offering.
    // ------------------------------------------------------------------
    initial
    begin
        int  mode;
        int  hold;
        bit  held;
        result.ready = 1'b0;
        mode = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= 40)
            begin
                held = 1'b1;
                hold = 3000;
                result.ready <= 1'b0;
                while (hold > 0)
                begin
                    @(negedge clk);
                    hold--;
                end
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       result.ready <= 1'b1;
                1:       result.ready <= ($urandom_range(0, 9) < 7);
                2:       result.ready <= ($urandom_range(0, 9) < 2);
                default: result.ready <= ($urandom_range(0, 99) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        u64 want;
        if (rst_n && result.valid && result.ready)
        begin
            results_seen <= results_seen + 1;
            if (cost_q.size() == 0)
            begin
                $error("cost beat with no prediction waiting: actual %0d",
                       $signed(result.cost));
                failed <= 1'b1;
            end
            else
            begin
                want = cost_q.pop_front();
                if (result.cost !== want)
                begin
                    $error("cost mismatch: expected %0d, actual %0d",
                           $signed(want), $signed(result.cost));
                    failed <= 1'b1;
                end
            end
        end
    end

    initial results_seen = 0;

    // Watchdog on total run length.
    longint cycles;

    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule
